// ===== rtl/core/cpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// cpcr_pkg
// Shared widths, item types and helpers for the circle pair collision
// resolver pipeline.
// ----------------------------------------------------------------------------
package cpcr_pkg;

   localparam int FLD_W     = 20;            // Q11.8 position / velocity
   localparam int RAD_W     = 16;            // Q8.8 radius
   localparam int MASS_W    = 16;
   localparam int DX_W      = FLD_W + 1;     // centre difference
   localparam int SQ_W      = 2 * FLD_W + 1; // one squared difference
   localparam int D2_W      = SQ_W + 1;      // squared distance
   localparam int RS_W      = RAD_W + 1;     // radius sum
   localparam int RS2_W     = 2 * RS_W;      // squared radius sum
   localparam int ROOT_W    = RS_W;          // distance, valid on overlap
   localparam int PEN_W     = RS_W + 1;
   localparam int MAG_W     = 16;            // shift and normal magnitudes
   localparam int SN_W      = MAG_W + 1;
   localparam int NORM_SH   = 15;            // normal is Q1.15
   localparam int SNUM_W    = PEN_W + ROOT_W;
   localparam int NNUM_W    = ROOT_W + NORM_SH;
   localparam int PROD_W    = FLD_W + SN_W;  // v * n
   localparam int DP_W      = PROD_W + 2;
   localparam int DPM_W     = PROD_W;        // |dp| magnitude
   localparam int QNUM_W    = MASS_W + DPM_W + 1;
   localparam int MSUM_W    = MASS_W + 1;
   localparam int Q_W       = DPM_W + 1;     // |q| <= 2 |dp|
   localparam int QN_W      = Q_W + MAG_W;
   localparam int VEL_SH    = 30;
   localparam int DV_W      = QN_W - VEL_SH;
   localparam int SUM_W     = DV_W + 2;

   // pipeline depth from accept edge to result strobe
   localparam int LATENCY   = 7 + ROOT_W + MAG_W + Q_W + 5;

   typedef enum logic [1:0] {
      HIT_NONE       = 2'd0,
      HIT_RESOLVED   = 2'd1,
      HIT_COINCIDENT = 2'd2
   } hit_type;

   typedef struct packed {
      logic signed [FLD_W-1:0]  a_pos_x;
      logic signed [FLD_W-1:0]  a_pos_y;
      logic signed [FLD_W-1:0]  a_vel_x;
      logic signed [FLD_W-1:0]  a_vel_y;
      logic        [RAD_W-1:0]  a_radius;
      logic        [MASS_W-1:0] a_mass;
      logic signed [FLD_W-1:0]  b_pos_x;
      logic signed [FLD_W-1:0]  b_pos_y;
      logic signed [FLD_W-1:0]  b_vel_x;
      logic signed [FLD_W-1:0]  b_vel_y;
      logic        [RAD_W-1:0]  b_radius;
      logic        [MASS_W-1:0] b_mass;
   } item_type;

   // per-pair context carried down the pipe, filled in as stages go
   typedef struct packed {
      item_type                 item;
      logic [1:0]               status;
      logic signed [DX_W-1:0]   dx;
      logic signed [DX_W-1:0]   dy;
      logic [RS_W-1:0]          rs;
      logic [MASS_W-1:0]        ma;
      logic [MASS_W-1:0]        mb;
      logic signed [SN_W-1:0]   sx;
      logic signed [SN_W-1:0]   sy;
      logic signed [SN_W-1:0]   nx;
      logic signed [SN_W-1:0]   ny;
      logic [MAG_W-1:0]         nx_mag;
      logic [MAG_W-1:0]         ny_mag;
      logic                     dp_neg;
   } ctx_type;

   function automatic logic signed [FLD_W-1:0] sat_fld(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-FLD_W:0] top;
      top = v[SUM_W-1:FLD_W-1];
      if ((&top) || (~|top)) begin
         return v[FLD_W-1:0];
      end else if (v[SUM_W-1]) begin
         return {1'b1, {(FLD_W-1){1'b0}}};
      end else begin
         return {1'b0, {(FLD_W-1){1'b1}}};
      end
   endfunction

   function automatic logic signed [SUM_W-1:0] signed_mag(input logic [DV_W-1:0] mag,
                                                         input logic neg);
      logic signed [SUM_W-1:0] v;
      v = SUM_W'(mag);
      return neg ? -v : v;
   endfunction

endpackage

// ===== rtl/core/circle_pair_collision_resolver_unit.sv =====
// ----------------------------------------------------------------------------
// circle_pair_collision_resolver_unit
// Overlap test, separation and elastic velocity exchange for two circles.
// ----------------------------------------------------------------------------
// A pair is taken on every clock edge where start is high; busy never rises,
// so one pair per clock is sustained with no gaps. Each result shows up as a
// one-cycle rsp_valid strobe, taken from the end of the vld_ff shift register,
// in order. There is no back pressure: the receiver must take every
// strobe. The depth is set by the chain of bit-serial units laid out as
// pipeline stages: a 17-stage square root for the centre distance, four
// 16-stage dividers for the shift and unit normal, and a 38-stage divider pair
// for the momentum exchange, plus a few multiply and add stages between them.
// Positions and velocities pass through unchanged when the circles do not
// touch or when the centres coincide (status 2); all outputs saturate.
// ----------------------------------------------------------------------------
module circle_pair_collision_resolver_unit
   import cpcr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     start,
   output logic                     busy,
   input  logic signed [FLD_W-1:0]  req_a_pos_x,
   input  logic signed [FLD_W-1:0]  req_a_pos_y,
   input  logic signed [FLD_W-1:0]  req_a_vel_x,
   input  logic signed [FLD_W-1:0]  req_a_vel_y,
   input  logic        [RAD_W-1:0]  req_a_radius,
   input  logic        [MASS_W-1:0] req_a_mass,
   input  logic signed [FLD_W-1:0]  req_b_pos_x,
   input  logic signed [FLD_W-1:0]  req_b_pos_y,
   input  logic signed [FLD_W-1:0]  req_b_vel_x,
   input  logic signed [FLD_W-1:0]  req_b_vel_y,
   input  logic        [RAD_W-1:0]  req_b_radius,
   input  logic        [MASS_W-1:0] req_b_mass,

   output logic                     rsp_valid,
   output logic        [1:0]        rsp_hit_status,
   output logic signed [FLD_W-1:0]  rsp_new_a_pos_x,
   output logic signed [FLD_W-1:0]  rsp_new_a_pos_y,
   output logic signed [FLD_W-1:0]  rsp_new_b_pos_x,
   output logic signed [FLD_W-1:0]  rsp_new_b_pos_y,
   output logic signed [FLD_W-1:0]  rsp_new_a_vel_x,
   output logic signed [FLD_W-1:0]  rsp_new_a_vel_y,
   output logic signed [FLD_W-1:0]  rsp_new_b_vel_x,
   output logic signed [FLD_W-1:0]  rsp_new_b_vel_y
);

   // fully pipelined, never stalls
   assign busy = 1'b0;

   // valid bit for each pipeline stage
   logic [LATENCY-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LATENCY-2:0], start & ~busy};
      end
   end

   assign rsp_valid = vld_ff[LATENCY-1];

   // ---------------------------------------------------------------- input
   item_type req_item;
   item_type in_ff;

   always_comb begin
      req_item.a_pos_x  = req_a_pos_x;
      req_item.a_pos_y  = req_a_pos_y;
      req_item.a_vel_x  = req_a_vel_x;
      req_item.a_vel_y  = req_a_vel_y;
      req_item.a_radius = req_a_radius;
      req_item.a_mass   = req_a_mass;
      req_item.b_pos_x  = req_b_pos_x;
      req_item.b_pos_y  = req_b_pos_y;
      req_item.b_vel_x  = req_b_vel_x;
      req_item.b_vel_y  = req_b_vel_y;
      req_item.b_radius = req_b_radius;
      req_item.b_mass   = req_b_mass;
   end

   always_ff @(posedge clock) begin
      in_ff <= req_item;
   end

   // ------------------------------------------- centre difference, radii
   ctx_type c2_in, c2_ff;

   always_comb begin
      c2_in        = '0;
      c2_in.item   = in_ff;
      c2_in.status = HIT_NONE;
      c2_in.dx     = DX_W'(in_ff.b_pos_x) - DX_W'(in_ff.a_pos_x);
      c2_in.dy     = DX_W'(in_ff.b_pos_y) - DX_W'(in_ff.a_pos_y);
      c2_in.rs     = RS_W'(in_ff.a_radius) + RS_W'(in_ff.b_radius);
      // a zero mass counts as one
      c2_in.ma     = (in_ff.a_mass == '0) ? MASS_W'(1) : in_ff.a_mass;
      c2_in.mb     = (in_ff.b_mass == '0) ? MASS_W'(1) : in_ff.b_mass;
   end

   always_ff @(posedge clock) begin
      c2_ff <= c2_in;
   end

   // ------------------------------------------------------------ squares
   ctx_type                  c3_ff;
   logic signed [2*DX_W-1:0] dxsq_in, dysq_in;
   logic [RS2_W-1:0]         rs2_in;
   logic [SQ_W-1:0]          dx2_ff, dy2_ff;
   logic [RS2_W-1:0]         rs2_ff;

   assign dxsq_in = c2_ff.dx * c2_ff.dx;
   assign dysq_in = c2_ff.dy * c2_ff.dy;
   assign rs2_in  = c2_ff.rs * c2_ff.rs;

   always_ff @(posedge clock) begin
      c3_ff  <= c2_ff;
      dx2_ff <= dxsq_in[SQ_W-1:0];
      dy2_ff <= dysq_in[SQ_W-1:0];
      rs2_ff <= rs2_in;
   end

   // ------------------------------------------------------- overlap test
   ctx_type          c4_in, c4_ff;
   logic [D2_W-1:0]  d2_in;
   logic [RS2_W-1:0] d2_ff;

   always_comb begin
      d2_in = D2_W'(dx2_ff) + D2_W'(dy2_ff);
      c4_in = c3_ff;
      if (d2_in <= D2_W'(rs2_ff)) begin
         c4_in.status = (d2_in == '0) ? HIT_COINCIDENT : HIT_RESOLVED;
      end else begin
         c4_in.status = HIT_NONE;
      end
   end

   always_ff @(posedge clock) begin
      c4_ff <= c4_in;
      d2_ff <= d2_in[RS2_W-1:0];   // below 2^34 whenever the pair overlaps
   end

   // ----------------------------------------------------- centre distance
   logic [ROOT_W-1:0] root_dist;
   ctx_type           ctxa_ff [ROOT_W];

   cpcr_sqrt u_sqrt (
      .clock      (clock),
      .radicand_i (d2_ff),
      .root_o     (root_dist)
   );

   always_ff @(posedge clock) begin
      ctxa_ff[0] <= c4_ff;
      for (int i = 1; i < ROOT_W; i++) begin
         ctxa_ff[i] <= ctxa_ff[i-1];
      end
   end

   // ------------------------------------------- penetration, magnitudes
   ctx_type                c5_ff;
   logic [PEN_W-1:0]       pen_ff;
   logic [ROOT_W-1:0]      adx_ff, ady_ff, dist_ff;
   logic signed [DX_W-1:0] adx_in, ady_in;

   assign adx_in = ctxa_ff[ROOT_W-1].dx[DX_W-1] ? -ctxa_ff[ROOT_W-1].dx
                                                 : ctxa_ff[ROOT_W-1].dx;
   assign ady_in = ctxa_ff[ROOT_W-1].dy[DX_W-1] ? -ctxa_ff[ROOT_W-1].dy
                                                 : ctxa_ff[ROOT_W-1].dy;

   always_ff @(posedge clock) begin
      c5_ff   <= ctxa_ff[ROOT_W-1];
      // distance <= rs, so the depth never goes negative
      pen_ff  <= {1'b0, ctxa_ff[ROOT_W-1].rs} - {1'b0, root_dist};
      adx_ff  <= adx_in[ROOT_W-1:0];   // |dx| <= distance on overlap
      ady_ff  <= ady_in[ROOT_W-1:0];
      dist_ff <= root_dist;
   end

   // ------------------------------------------------ divider numerators
   ctx_type            c6_ff;
   logic [SNUM_W-1:0]  sxnum_in, synum_in;
   logic [SNUM_W-1:0]  sxnum_ff, synum_ff;
   logic [NNUM_W-1:0]  nxnum_ff, nynum_ff;
   logic [ROOT_W-1:0]  dist6_ff;

   assign sxnum_in = pen_ff * adx_ff;
   assign synum_in = pen_ff * ady_ff;

   always_ff @(posedge clock) begin
      c6_ff    <= c5_ff;
      sxnum_ff <= sxnum_in;
      synum_ff <= synum_in;
      nxnum_ff <= {adx_ff, {NORM_SH{1'b0}}};
      nynum_ff <= {ady_ff, {NORM_SH{1'b0}}};
      dist6_ff <= dist_ff;
   end

   // shift = pen*|d| / (2 dist), normal = |d| * 2^15 / dist
   logic [MAG_W-1:0] sx_mag, sy_mag, nx_mag, ny_mag;
   ctx_type          ctxb_ff [MAG_W];

   cpcr_div #(.NUM_W(SNUM_W), .DEN_W(ROOT_W + 1), .QUO_W(MAG_W)) u_div_sx (
      .clock (clock), .num_i (sxnum_ff), .den_i ({dist6_ff, 1'b0}), .quo_o (sx_mag)
   );

   cpcr_div #(.NUM_W(SNUM_W), .DEN_W(ROOT_W + 1), .QUO_W(MAG_W)) u_div_sy (
      .clock (clock), .num_i (synum_ff), .den_i ({dist6_ff, 1'b0}), .quo_o (sy_mag)
   );

   cpcr_div #(.NUM_W(NNUM_W), .DEN_W(ROOT_W), .QUO_W(MAG_W)) u_div_nx (
      .clock (clock), .num_i (nxnum_ff), .den_i (dist6_ff), .quo_o (nx_mag)
   );

   cpcr_div #(.NUM_W(NNUM_W), .DEN_W(ROOT_W), .QUO_W(MAG_W)) u_div_ny (
      .clock (clock), .num_i (nynum_ff), .den_i (dist6_ff), .quo_o (ny_mag)
   );

   always_ff @(posedge clock) begin
      ctxb_ff[0] <= c6_ff;
      for (int i = 1; i < MAG_W; i++) begin
         ctxb_ff[i] <= ctxb_ff[i-1];
      end
   end

   // ------------------------------------------------- signed shift/normal
   ctx_type c7_in, c7_ff;
   logic    xneg_b, yneg_b;

   always_comb begin
      c7_in  = ctxb_ff[MAG_W-1];
      xneg_b = c7_in.dx[DX_W-1];
      yneg_b = c7_in.dy[DX_W-1];
      c7_in.sx     = xneg_b ? -SN_W'(sx_mag) : SN_W'(sx_mag);
      c7_in.sy     = yneg_b ? -SN_W'(sy_mag) : SN_W'(sy_mag);
      c7_in.nx     = xneg_b ? -SN_W'(nx_mag) : SN_W'(nx_mag);
      c7_in.ny     = yneg_b ? -SN_W'(ny_mag) : SN_W'(ny_mag);
      c7_in.nx_mag = nx_mag;
      c7_in.ny_mag = ny_mag;
   end

   always_ff @(posedge clock) begin
      c7_ff <= c7_in;
   end

   // ------------------------------------------- normal velocity products
   ctx_type                  c8_ff;
   logic signed [PROD_W-1:0] pax_in, pay_in, pbx_in, pby_in;
   logic signed [PROD_W-1:0] pax_ff, pay_ff, pbx_ff, pby_ff;

   assign pax_in = c7_ff.item.a_vel_x * c7_ff.nx;
   assign pay_in = c7_ff.item.a_vel_y * c7_ff.ny;
   assign pbx_in = c7_ff.item.b_vel_x * c7_ff.nx;
   assign pby_in = c7_ff.item.b_vel_y * c7_ff.ny;

   always_ff @(posedge clock) begin
      c8_ff  <= c7_ff;
      pax_ff <= pax_in;
      pay_ff <= pay_in;
      pbx_ff <= pbx_in;
      pby_ff <= pby_in;
   end

   // ------------------------------------------------ relative momentum
   ctx_type                c9_in, c9_ff;
   logic signed [DP_W-1:0] pa_in, pb_in, dp_in, dpabs_in;
   logic [DPM_W-1:0]       dpm_ff;

   always_comb begin
      pa_in    = DP_W'(pax_ff) + DP_W'(pay_ff);
      pb_in    = DP_W'(pbx_ff) + DP_W'(pby_ff);
      dp_in    = pb_in - pa_in;
      dpabs_in = dp_in[DP_W-1] ? -dp_in : dp_in;
      c9_in        = c8_ff;
      c9_in.dp_neg = dp_in[DP_W-1];
   end

   always_ff @(posedge clock) begin
      c9_ff  <= c9_in;
      dpm_ff <= dpabs_in[DPM_W-1:0];
   end

   // -------------------------------------------- mass weighted numerators
   ctx_type            c10_ff;
   logic [QNUM_W-2:0]  mbdp_in, madp_in;
   logic [QNUM_W-1:0]  numa_ff, numb_ff;
   logic [MSUM_W-1:0]  msum_ff;

   assign mbdp_in = c9_ff.mb * dpm_ff;
   assign madp_in = c9_ff.ma * dpm_ff;

   always_ff @(posedge clock) begin
      c10_ff  <= c9_ff;
      numa_ff <= {mbdp_in, 1'b0};
      numb_ff <= {madp_in, 1'b0};
      msum_ff <= MSUM_W'(c9_ff.ma) + MSUM_W'(c9_ff.mb);
   end

   // |qa| = 2 mb |dp| / msum, |qb| = 2 ma |dp| / msum
   logic [Q_W-1:0] qa_mag, qb_mag;
   ctx_type        ctxc_ff [Q_W];

   cpcr_div #(.NUM_W(QNUM_W), .DEN_W(MSUM_W), .QUO_W(Q_W)) u_div_qa (
      .clock (clock), .num_i (numa_ff), .den_i (msum_ff), .quo_o (qa_mag)
   );

   cpcr_div #(.NUM_W(QNUM_W), .DEN_W(MSUM_W), .QUO_W(Q_W)) u_div_qb (
      .clock (clock), .num_i (numb_ff), .den_i (msum_ff), .quo_o (qb_mag)
   );

   always_ff @(posedge clock) begin
      ctxc_ff[0] <= c10_ff;
      for (int i = 1; i < Q_W; i++) begin
         ctxc_ff[i] <= ctxc_ff[i-1];
      end
   end

   // ------------------------------------------- velocity change products
   ctx_type          c11_ff;
   logic [QN_W-1:0]  tax_in, tay_in, tbx_in, tby_in;
   logic [QN_W-1:0]  tax_ff, tay_ff, tbx_ff, tby_ff;

   assign tax_in = qa_mag * ctxc_ff[Q_W-1].nx_mag;
   assign tay_in = qa_mag * ctxc_ff[Q_W-1].ny_mag;
   assign tbx_in = qb_mag * ctxc_ff[Q_W-1].nx_mag;
   assign tby_in = qb_mag * ctxc_ff[Q_W-1].ny_mag;

   always_ff @(posedge clock) begin
      c11_ff <= ctxc_ff[Q_W-1];
      tax_ff <= tax_in;
      tay_ff <= tay_in;
      tbx_ff <= tbx_in;
      tby_ff <= tby_in;
   end

   // ----------------------------------------------- final add, saturate
   // qa carries the sign of dp, qb the opposite; the normal the sign of d.
   logic                    xneg_f, yneg_f, qa_neg;
   logic signed [SUM_W-1:0] dvax, dvay, dvbx, dvby;
   logic signed [FLD_W-1:0] nax_in, nay_in, nbx_in, nby_in;
   logic signed [FLD_W-1:0] navx_in, navy_in, nbvx_in, nbvy_in;

   always_comb begin
      xneg_f = c11_ff.dx[DX_W-1];
      yneg_f = c11_ff.dy[DX_W-1];
      qa_neg = c11_ff.dp_neg;
      dvax = signed_mag(tax_ff[QN_W-1:VEL_SH], qa_neg ^ xneg_f);
      dvay = signed_mag(tay_ff[QN_W-1:VEL_SH], qa_neg ^ yneg_f);
      dvbx = signed_mag(tbx_ff[QN_W-1:VEL_SH], ~qa_neg ^ xneg_f);
      dvby = signed_mag(tby_ff[QN_W-1:VEL_SH], ~qa_neg ^ yneg_f);

      if (c11_ff.status == HIT_RESOLVED) begin
         nax_in  = sat_fld(SUM_W'(c11_ff.item.a_pos_x) - SUM_W'(c11_ff.sx));
         nay_in  = sat_fld(SUM_W'(c11_ff.item.a_pos_y) - SUM_W'(c11_ff.sy));
         nbx_in  = sat_fld(SUM_W'(c11_ff.item.b_pos_x) + SUM_W'(c11_ff.sx));
         nby_in  = sat_fld(SUM_W'(c11_ff.item.b_pos_y) + SUM_W'(c11_ff.sy));
         navx_in = sat_fld(SUM_W'(c11_ff.item.a_vel_x) + dvax);
         navy_in = sat_fld(SUM_W'(c11_ff.item.a_vel_y) + dvay);
         nbvx_in = sat_fld(SUM_W'(c11_ff.item.b_vel_x) + dvbx);
         nbvy_in = sat_fld(SUM_W'(c11_ff.item.b_vel_y) + dvby);
      end else begin
         nax_in  = c11_ff.item.a_pos_x;
         nay_in  = c11_ff.item.a_pos_y;
         nbx_in  = c11_ff.item.b_pos_x;
         nby_in  = c11_ff.item.b_pos_y;
         navx_in = c11_ff.item.a_vel_x;
         navy_in = c11_ff.item.a_vel_y;
         nbvx_in = c11_ff.item.b_vel_x;
         nbvy_in = c11_ff.item.b_vel_y;
      end
   end

   logic [1:0]              hit_ff;
   logic signed [FLD_W-1:0] nax_ff, nay_ff, nbx_ff, nby_ff;
   logic signed [FLD_W-1:0] navx_ff, navy_ff, nbvx_ff, nbvy_ff;

   always_ff @(posedge clock) begin
      hit_ff  <= c11_ff.status;
      nax_ff  <= nax_in;
      nay_ff  <= nay_in;
      nbx_ff  <= nbx_in;
      nby_ff  <= nby_in;
      navx_ff <= navx_in;
      navy_ff <= navy_in;
      nbvx_ff <= nbvx_in;
      nbvy_ff <= nbvy_in;
   end

   assign rsp_hit_status  = hit_ff;
   assign rsp_new_a_pos_x = nax_ff;
   assign rsp_new_a_pos_y = nay_ff;
   assign rsp_new_b_pos_x = nbx_ff;
   assign rsp_new_b_pos_y = nby_ff;
   assign rsp_new_a_vel_x = navx_ff;
   assign rsp_new_a_vel_y = navy_ff;
   assign rsp_new_b_vel_x = nbvx_ff;
   assign rsp_new_b_vel_y = nbvy_ff;

endmodule

// ===== rtl/core/cpcr_sqrt.sv =====
// ----------------------------------------------------------------------------
// cpcr_sqrt
// Pipelined floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module cpcr_sqrt
   import cpcr_pkg::*;
(
   input  logic              clock,
   input  logic [RS2_W-1:0]  radicand_i,
   output logic [ROOT_W-1:0] root_o
);

   localparam int REM_W = ROOT_W + 2;
   localparam int TRY_W = REM_W + 2;

   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RS2_W-1:0]  rad_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_step
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [RS2_W-1:0]  rad_prev;
      logic [TRY_W-1:0]  acc;
      logic [TRY_W-1:0]  trial;

      if (i == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand_i;
      end else begin : g_next
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
      end

      // bring down the next two radicand bits, try (4*root + 1)
      assign acc   = {rem_prev, rad_prev[RS2_W-1 -: 2]};
      assign trial = TRY_W'({root_prev, 2'b01});

      always_ff @(posedge clock) begin
         if (acc >= trial) begin
            rem_ff[i]  <= REM_W'(acc - trial);
            root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[i]  <= REM_W'(acc);
            root_ff[i] <= {root_prev[ROOT_W-2:0], 1'b0};
         end
         rad_ff[i] <= rad_prev << 2;
      end
   end

   assign root_o = root_ff[ROOT_W-1];

endmodule

// ===== rtl/core/cpcr_div.sv =====
// ----------------------------------------------------------------------------
// cpcr_div
// Pipelined restoring divider for unsigned operands, one quotient bit per
// stage. The quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module cpcr_div #(
   parameter int NUM_W = 32,
   parameter int DEN_W = 17,
   parameter int QUO_W = 16
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num_i,
   input  logic [DEN_W-1:0] den_i,
   output logic [QUO_W-1:0] quo_o
);

   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] low_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];

   for (genvar i = 0; i < QUO_W; i++) begin : g_step
      logic [DEN_W-1:0] rem_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [QUO_W-1:0] low_prev;
      logic [DEN_W-1:0] den_prev;
      logic [DEN_W:0]   trial;
      logic             ge;

      if (i == 0) begin : g_first
         // upper numerator bits are already below the divisor
         assign rem_prev = DEN_W'(num_i >> QUO_W);
         assign quo_prev = '0;
         assign low_prev = num_i[QUO_W-1:0];
         assign den_prev = den_i;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign low_prev = low_ff[i-1];
         assign den_prev = den_ff[i-1];
      end

      assign trial = {rem_prev, low_prev[QUO_W-1]};
      assign ge    = (trial >= {1'b0, den_prev});

      always_ff @(posedge clock) begin
         rem_ff[i] <= ge ? DEN_W'(trial - {1'b0, den_prev}) : DEN_W'(trial);
         quo_ff[i] <= {quo_prev[QUO_W-2:0], ge};
         low_ff[i] <= low_prev << 1;
         den_ff[i] <= den_prev;
      end
   end

   assign quo_o = quo_ff[QUO_W-1];

endmodule

// ===== rtl/core/cpcr_checker.sv =====
// ----------------------------------------------------------------------------
// cpcr_checker
// Port-level checks on the collision resolver, bound to the top level.
// ----------------------------------------------------------------------------
module cpcr_checker
   import cpcr_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic signed [FLD_W-1:0]  req_a_pos_x,
   input logic signed [FLD_W-1:0]  req_b_vel_y,
   input logic                     rsp_valid,
   input logic        [1:0]        rsp_hit_status,
   input logic signed [FLD_W-1:0]  rsp_new_a_pos_x,
   input logic signed [FLD_W-1:0]  rsp_new_b_vel_y
);

   // every accepted pair comes out after a fixed depth
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("result missing after accepted pair");

   // no result without a pair behind it
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LATENCY !rsp_valid)
      else $error("result strobe without accepted pair");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit_status == HIT_NONE || rsp_hit_status == HIT_RESOLVED ||
                     rsp_hit_status == HIT_COINCIDENT))
      else $error("undefined hit status");

   // pairs that miss or whose centres coincide pass through unchanged
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_hit_status == HIT_NONE || rsp_hit_status == HIT_COINCIDENT))
      |-> (rsp_new_a_pos_x == $past(req_a_pos_x, LATENCY) &&
           rsp_new_b_vel_y == $past(req_b_vel_y, LATENCY)))
      else $error("unresolved pair was modified");

endmodule

bind circle_pair_collision_resolver_unit cpcr_checker u_cpcr_checker (.*);

// ===== tb/cpcr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cpcr_scoreboard
// Watches the pair and result channels, predicts each result from the pair
// and compares it field by field with what the resolver returns.
// ----------------------------------------------------------------------------
module cpcr_scoreboard
   import cpcr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  item_type                 pair,
   input  logic                     rsp_valid,
   input  logic        [1:0]        rsp_hit_status,
   input  logic signed [FLD_W-1:0]  rsp_new_a_pos_x,
   input  logic signed [FLD_W-1:0]  rsp_new_a_pos_y,
   input  logic signed [FLD_W-1:0]  rsp_new_b_pos_x,
   input  logic signed [FLD_W-1:0]  rsp_new_b_pos_y,
   input  logic signed [FLD_W-1:0]  rsp_new_a_vel_x,
   input  logic signed [FLD_W-1:0]  rsp_new_a_vel_y,
   input  logic signed [FLD_W-1:0]  rsp_new_b_vel_x,
   input  logic signed [FLD_W-1:0]  rsp_new_b_vel_y,
   output int                       fail_count,
   output int                       pending
);

   typedef struct packed {
      logic [1:0]              status;
      logic signed [FLD_W-1:0] ax, ay, bx, by, avx, avy, bvx, bvy;
   } outcome_type;

   outcome_type outcome_q[$];

   function automatic logic signed [FLD_W-1:0] clamp_fld(input longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v[FLD_W-1:0];
   endfunction

   function automatic longint isqrt(input longint x);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= x)
            r = r + (longint'(1) << b);
      end
      return r;
   endfunction

   function automatic outcome_type resolve_pair(input item_type p);
      outcome_type o;
      longint ax, ay, avx, avy, bx, by, bvx, bvy, ma, mb;
      longint dx, dy, d2, rs, root, pen, sx, sy, nx, ny, dp, qa, qb, msum;
      ax = p.a_pos_x; ay = p.a_pos_y; avx = p.a_vel_x; avy = p.a_vel_y;
      bx = p.b_pos_x; by = p.b_pos_y; bvx = p.b_vel_x; bvy = p.b_vel_y;
      ma = p.a_mass; mb = p.b_mass;
      if (ma == 0) ma = 1;
      if (mb == 0) mb = 1;
      o = {HIT_NONE, p.a_pos_x, p.a_pos_y, p.b_pos_x, p.b_pos_y,
           p.a_vel_x, p.a_vel_y, p.b_vel_x, p.b_vel_y};
      dx = bx - ax; dy = by - ay;
      d2 = dx * dx + dy * dy;
      rs = longint'(p.a_radius) + longint'(p.b_radius);
      if (d2 <= rs * rs) begin
         if (d2 == 0) begin
            o.status = HIT_COINCIDENT;
         end else begin
            root = isqrt(d2);
            pen  = rs - root;
            sx = (pen * dx) / (2 * root);
            sy = (pen * dy) / (2 * root);
            nx = (dx * 32768) / root;
            ny = (dy * 32768) / root;
            dp = (bvx * nx + bvy * ny) - (avx * nx + avy * ny);
            msum = ma + mb;
            qa = (2 * mb * dp) / msum;
            qb = (2 * ma * (-dp)) / msum;
            o.status = HIT_RESOLVED;
            o.ax  = clamp_fld(ax - sx);
            o.ay  = clamp_fld(ay - sy);
            o.bx  = clamp_fld(bx + sx);
            o.by  = clamp_fld(by + sy);
            o.avx = clamp_fld(avx + (qa * nx) / (longint'(1) << 30));
            o.avy = clamp_fld(avy + (qa * ny) / (longint'(1) << 30));
            o.bvx = clamp_fld(bvx + (qb * nx) / (longint'(1) << 30));
            o.bvy = clamp_fld(bvy + (qb * ny) / (longint'(1) << 30));
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want, got;
      if (reset) begin
         fail_count <= 0;
         pending    <= 0;
      end else begin
         if (start && !busy) outcome_q = {outcome_q, resolve_pair(pair)};
         if (rsp_valid) begin
            got = {rsp_hit_status, rsp_new_a_pos_x, rsp_new_a_pos_y, rsp_new_b_pos_x,
                   rsp_new_b_pos_y, rsp_new_a_vel_x, rsp_new_a_vel_y,
                   rsp_new_b_vel_x, rsp_new_b_vel_y};
            if (outcome_q.size() == 0) begin
               $display("%0t: unexpected result transfer %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = outcome_q.pop_front();
               if (want !== got) begin
                  $display("%0t: mismatch expected st=%0d %0d %0d %0d %0d v %0d %0d %0d %0d",
                           $time, want.status, want.ax, want.ay, want.bx, want.by,
                           want.avx, want.avy, want.bvx, want.bvy);
                  $display("%0t:          actual   st=%0d %0d %0d %0d %0d v %0d %0d %0d %0d",
                           $time, got.status, got.ax, got.ay, got.bx, got.by,
                           got.avx, got.avy, got.bvx, got.bvy);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= outcome_q.size();
      end
   end

endmodule

// ===== tb/tb_circle_pair_collision_resolver_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circle_pair_collision_resolver_unit
// Feeds directed and random circle pairs (mostly overlapping, some apart,
// some coincident) with random start gaps; the scoreboard predicts and compares.
// ----------------------------------------------------------------------------
module tb_circle_pair_collision_resolver_unit;
   import cpcr_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   item_type pair = '0;
   logic rsp_valid;
   logic [1:0] rsp_hit_status;
   logic signed [FLD_W-1:0] n_ax, n_ay, n_bx, n_by, n_avx, n_avy, n_bvx, n_bvy;
   int fail_count, pending;

   always #10 clock = ~clock;

   circle_pair_collision_resolver_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_pos_x(pair.a_pos_x), .req_a_pos_y(pair.a_pos_y),
      .req_a_vel_x(pair.a_vel_x), .req_a_vel_y(pair.a_vel_y),
      .req_a_radius(pair.a_radius), .req_a_mass(pair.a_mass),
      .req_b_pos_x(pair.b_pos_x), .req_b_pos_y(pair.b_pos_y),
      .req_b_vel_x(pair.b_vel_x), .req_b_vel_y(pair.b_vel_y),
      .req_b_radius(pair.b_radius), .req_b_mass(pair.b_mass),
      .rsp_valid(rsp_valid), .rsp_hit_status(rsp_hit_status),
      .rsp_new_a_pos_x(n_ax), .rsp_new_a_pos_y(n_ay),
      .rsp_new_b_pos_x(n_bx), .rsp_new_b_pos_y(n_by),
      .rsp_new_a_vel_x(n_avx), .rsp_new_a_vel_y(n_avy),
      .rsp_new_b_vel_x(n_bvx), .rsp_new_b_vel_y(n_bvy)
   );

   cpcr_scoreboard u_scoreboard (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .pair(pair),
      .rsp_valid(rsp_valid), .rsp_hit_status(rsp_hit_status),
      .rsp_new_a_pos_x(n_ax), .rsp_new_a_pos_y(n_ay),
      .rsp_new_b_pos_x(n_bx), .rsp_new_b_pos_y(n_by),
      .rsp_new_a_vel_x(n_avx), .rsp_new_a_vel_y(n_avy),
      .rsp_new_b_vel_x(n_bvx), .rsp_new_b_vel_y(n_bvy),
      .fail_count(fail_count), .pending(pending)
   );

   // Hold one pair on the ports until it is taken; a gap burst may come first.
   // start stays high between back-to-back transfers (one NBA per edge).
   task automatic send_pair(input item_type p, input bit allow_gap);
      if (allow_gap && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      start <= 1'b1;
      pair  <= p;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic signed [FLD_W-1:0] rand_fld();
      return FLD_W'($urandom);
   endfunction

   // Pair built around a random point; kind 0 gives noise, kind 1 a coincident pair,
   // others nearby centres; span picks 4000 or 60000 as the offset scale at even odds.
   function automatic item_type make_pair(input int unsigned kind);
      item_type p;
      int span;
      p.a_vel_x = rand_fld(); p.a_vel_y = rand_fld();
      p.b_vel_x = rand_fld(); p.b_vel_y = rand_fld();
      if ($urandom_range(0, 3) == 0) begin
         p.a_vel_x = FLD_W'($signed(FLD_W'($urandom_range(0, 8191))) - 4096);
         p.b_vel_y = FLD_W'($signed(FLD_W'($urandom_range(0, 8191))) - 4096);
      end
      p.a_mass = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                               : 16'($urandom);
      p.b_mass = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 2))
                                               : 16'($urandom);
      p.a_radius = 16'($urandom);
      p.b_radius = 16'($urandom);
      p.a_pos_x = rand_fld(); p.a_pos_y = rand_fld();
      span = ($urandom_range(0, 1)) ? 4000 : 60000;
      case (kind)
         0: begin  // random noise, rarely overlapping
            p.b_pos_x = rand_fld(); p.b_pos_y = rand_fld();
         end
         1: begin  // coincident
            p.b_pos_x = p.a_pos_x; p.b_pos_y = p.a_pos_y;
         end
         default: begin  // nearby centres, positions may wrap at the field edges
            p.b_pos_x = FLD_W'(p.a_pos_x
                               + $signed(FLD_W'($urandom_range(0, 2 * span))) - span);
            p.b_pos_y = FLD_W'(p.a_pos_y
                               + $signed(FLD_W'($urandom_range(0, 2 * span))) - span);
         end
      endcase
      return p;
   endfunction

   initial begin
      item_type p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, coincident, zero radii, zero mass, touching
      p = '0;                                         send_pair(p, 0);
      p.a_radius = 16'hFFFF; p.b_radius = 16'hFFFF;   send_pair(p, 0);
      p = '0; p.b_pos_x = 20'sd256; p.a_radius = 16'd128; p.b_radius = 16'd128;
      p.a_mass = 16'd1; p.b_mass = 16'd1; p.a_vel_x = 20'sd512;
      send_pair(p, 0);                                // touching exactly
      p.b_pos_x = 20'sd100; p.a_mass = '0; p.b_mass = 16'hFFFF;
      send_pair(p, 0);
      p.a_pos_x = -20'sd524288; p.b_pos_x = -20'sd524200;
      p.a_vel_x = 20'sd524287; p.b_vel_x = -20'sd524288;
      p.a_vel_y = -20'sd524288; p.b_vel_y = 20'sd524287;
      p.a_pos_y = 20'sd524287; p.b_pos_y = 20'sd524250;
      p.a_mass = 16'hFFFF; p.b_mass = 16'd1; p.a_radius = 16'hFFFF;
      send_pair(p, 0);
      p.b_pos_x = 20'sd524287; p.a_pos_x = 20'sd524200; send_pair(p, 0);
      p = '1; send_pair(p, 0);
      p = '0; p.a_pos_x = -20'sd524288; p.b_pos_x = 20'sd524287;
      p.a_radius = 16'hFFFF; p.b_radius = 16'hFFFF; send_pair(p, 0);
      p.a_pos_x = 20'sd1; p.b_pos_x = '0; p.a_pos_y = 20'sd1; send_pair(p, 0);
      for (int k = 0; k < 3; k++) send_pair(make_pair(k), 0);

      // random: mostly close pairs, some coincident, some noise
      for (int i = 0; i < 1900; i++) begin
         int unsigned r;
         r = $urandom_range(0, 9);
         send_pair(make_pair(r == 0 ? 0 : (r == 1 ? 1 : 2)), i < 1700);
      end
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/cpcr_pkg.sv
rtl/core/cpcr_sqrt.sv
rtl/core/cpcr_div.sv
rtl/core/circle_pair_collision_resolver_unit.sv
rtl/core/cpcr_checker.sv
tb/cpcr_checker.sv
tb/tb_circle_pair_collision_resolver_unit.sv
